[hdl/tnu3d_pkg.sv]
package tnu3d_pkg;

	// Field widths of the configuration registers and of the result address.
	localparam int FACTOR_W  = 3;
	localparam int DIM_REG_W = 9;
	localparam int CHAN_REG_W = 5;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W = 34;

	// Enlarged size along one axis and the size of one enlarged plane.
	localparam int EXT_W = DIM_REG_W + FACTOR_W;
	localparam int HW_W = 2 * EXT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_FACTOR  = 3'd0,
		REG_HEIGHT_FACTOR = 3'd1,
		REG_DEPTH_FACTOR  = 3'd2,
		REG_IN_WIDTH      = 3'd3,
		REG_IN_HEIGHT     = 3'd4,
		REG_IN_DEPTH      = 3'd5,
		REG_CHANNEL_COUNT = 3'd6
	} reg_idx_t;

	// Configuration after range limiting.
	typedef struct packed {
		logic [FACTOR_W-1:0]   wf;
		logic [FACTOR_W-1:0]   hf;
		logic [FACTOR_W-1:0]   df;
		logic [DIM_REG_W-1:0]  iw;
		logic [DIM_REG_W-1:0]  ih;
		logic [DIM_REG_W-1:0]  id;
		logic [CHAN_REG_W-1:0] nc;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul2;
		logic mul3;
		logic mul4;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_copy;
	} sts_t;

endpackage

[hdl/tnu3d_cfg.sv]
module tnu3d_cfg #(
	parameter int MAX_FACTOR = 4,
	parameter int MAX_DIM = 256,
	parameter int MAX_CHANNELS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [tnu3d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tnu3d_pkg::CFG_DATA_W-1:0]     cfg_data,
	output tnu3d_pkg::cfg_t                      cfg
);
	import tnu3d_pkg::*;

	localparam logic [FACTOR_W-1:0] FMAX =
		(MAX_FACTOR > 7) ? FACTOR_W'(7) : FACTOR_W'(MAX_FACTOR);
	localparam logic [DIM_REG_W-1:0] DMAX =
		(MAX_DIM > 511) ? DIM_REG_W'(511) : DIM_REG_W'(MAX_DIM);
	localparam logic [CHAN_REG_W-1:0] CMAX =
		(MAX_CHANNELS > 31) ? CHAN_REG_W'(31) : CHAN_REG_W'(MAX_CHANNELS);

	logic [FACTOR_W-1:0]   wf_q, hf_q, df_q;
	logic [DIM_REG_W-1:0]  iw_q, ih_q, id_q;
	logic [CHAN_REG_W-1:0] nc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q <= FACTOR_W'(1);
			hf_q <= FACTOR_W'(1);
			df_q <= FACTOR_W'(1);
			iw_q <= DIM_REG_W'(1);
			ih_q <= DIM_REG_W'(1);
			id_q <= DIM_REG_W'(1);
			nc_q <= CHAN_REG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH_FACTOR:  wf_q <= cfg_data[FACTOR_W-1:0];
				REG_HEIGHT_FACTOR: hf_q <= cfg_data[FACTOR_W-1:0];
				REG_DEPTH_FACTOR:  df_q <= cfg_data[FACTOR_W-1:0];
				REG_IN_WIDTH:      iw_q <= cfg_data[DIM_REG_W-1:0];
				REG_IN_HEIGHT:     ih_q <= cfg_data[DIM_REG_W-1:0];
				REG_IN_DEPTH:      id_q <= cfg_data[DIM_REG_W-1:0];
				REG_CHANNEL_COUNT: nc_q <= cfg_data[CHAN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Zero counts as one; anything above the supported maximum saturates.
	always_comb begin
		cfg.wf = (wf_q == '0) ? FACTOR_W'(1) : ((wf_q > FMAX) ? FMAX : wf_q);
		cfg.hf = (hf_q == '0) ? FACTOR_W'(1) : ((hf_q > FMAX) ? FMAX : hf_q);
		cfg.df = (df_q == '0) ? FACTOR_W'(1) : ((df_q > FMAX) ? FMAX : df_q);
		cfg.iw = (iw_q == '0) ? DIM_REG_W'(1) : ((iw_q > DMAX) ? DMAX : iw_q);
		cfg.ih = (ih_q == '0) ? DIM_REG_W'(1) : ((ih_q > DMAX) ? DMAX : ih_q);
		cfg.id = (id_q == '0) ? DIM_REG_W'(1) : ((id_q > DMAX) ? DMAX : id_q);
		cfg.nc = (nc_q == '0) ? CHAN_REG_W'(1) : ((nc_q > CMAX) ? CMAX : nc_q);
	end

endmodule

[hdl/tnu3d_ctrl.sv]
module tnu3d_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tnu3d_pkg::sts_t   sts,
	output tnu3d_pkg::cmd_t   cmd
);
	import tnu3d_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL2 = 5'b00010,
		ST_MUL3 = 5'b00100,
		ST_MUL4 = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && s_tvalid;
		cmd.mul2 = (state_q == ST_MUL2);
		cmd.mul3 = (state_q == ST_MUL3);
		cmd.mul4 = (state_q == ST_MUL4);
		cmd.emit = (state_q == ST_EMIT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_MUL4;
			ST_MUL4: state_d = ST_EMIT;
			ST_EMIT: if (sts.out_free && sts.last_copy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_MUL2)
		else $error("accepted request did not start the address setup");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last_copy |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after the final copy");
	a_emit_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_EMIT && sts.out_free)
		else $error("copy issued while the output register was occupied");
`endif

endmodule

[hdl/tnu3d_dp.sv]
module tnu3d_dp #(
	parameter int MAX_DIM = 256,
	parameter int MAX_CHANNELS = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  tnu3d_pkg::cfg_t                                       cfg,
	input  tnu3d_pkg::cmd_t                                       cmd,
	output tnu3d_pkg::sts_t                                       sts,
	input  logic [DATA_WIDTH-1:0]                                 sample,
	output logic                                                  m_tvalid,
	input  logic                                                  m_tready,
	output logic [((tnu3d_pkg::ADDR_W+DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
	output logic                                                  m_tlast,
	output logic                                                  m_tuser
);
	import tnu3d_pkg::*;

	localparam int X_W = $clog2(MAX_DIM);
	localparam int C_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int O_W = X_W + FACTOR_W;
	localparam int OUT_W = ((ADDR_W + DATA_WIDTH + 7) / 8) * 8;

	// Position of the next input element.
	logic [X_W-1:0] x_q, y_q, z_q;
	logic [C_W-1:0] c_q;
	logic x_end, y_end, z_end, c_end;

	// Per-element working registers.
	logic [C_W-1:0]        c_work_q;
	logic [EXT_W-1:0]      ext_w_q, ext_h_q, ext_d_q;
	logic [O_W-1:0]        ox_q, oy_q, oz_q;
	logic [HW_W-1:0]       hw_q;
	logic [ADDR_W-1:0]     t1_q, t2_q;
	logic [ADDR_W-1:0]     addr_q, row_q, plane_q;
	logic [FACTOR_W-1:0]   dx_q, dy_q, dz_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic                  last_elem_q;
	logic                  last_x, last_y, last_z;
	logic [ADDR_W-1:0]     row_next, plane_next;

	assign x_end = 32'(x_q) >= 32'(cfg.iw) - 32'd1;
	assign y_end = 32'(y_q) >= 32'(cfg.ih) - 32'd1;
	assign z_end = 32'(z_q) >= 32'(cfg.id) - 32'd1;
	assign c_end = 32'(c_q) >= 32'(cfg.nc) - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			c_q <= '0;
		end else if (cmd.load) begin
			if (!x_end) begin
				x_q <= x_q + 1'b1;
			end else begin
				x_q <= '0;
				if (!y_end) begin
					y_q <= y_q + 1'b1;
				end else begin
					y_q <= '0;
					if (!z_end) begin
						z_q <= z_q + 1'b1;
					end else begin
						z_q <= '0;
						c_q <= c_end ? '0 : c_q + 1'b1;
					end
				end
			end
		end
	end

	assign last_x = (dx_q == cfg.wf - 1'b1);
	assign last_y = (dy_q == cfg.hf - 1'b1);
	assign last_z = (dz_q == cfg.df - 1'b1);
	assign row_next = row_q + ADDR_W'(ext_w_q);
	assign plane_next = plane_q + ADDR_W'(hw_q);

	assign sts.last_copy = last_x && last_y && last_z;
	assign sts.out_free = !m_tvalid || m_tready;

	// Base address ((c*D + oz)*H + oy)*W + ox is built in the load, mul2, mul3
	// and mul4 steps; the copies then step through it by additions.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q     <= sample;
			c_work_q    <= c_q;
			last_elem_q <= x_end && y_end && z_end && c_end;
			ext_w_q     <= EXT_W'(cfg.iw) * EXT_W'(cfg.wf);
			ext_h_q     <= EXT_W'(cfg.ih) * EXT_W'(cfg.hf);
			ext_d_q     <= EXT_W'(cfg.id) * EXT_W'(cfg.df);
			ox_q        <= O_W'(x_q) * O_W'(cfg.wf);
			oy_q        <= O_W'(y_q) * O_W'(cfg.hf);
			oz_q        <= O_W'(z_q) * O_W'(cfg.df);
		end
		if (cmd.mul2) begin
			t1_q <= ADDR_W'(c_work_q) * ADDR_W'(ext_d_q) + ADDR_W'(oz_q);
			hw_q <= HW_W'(ext_h_q) * HW_W'(ext_w_q);
		end
		if (cmd.mul3) begin
			t2_q <= t1_q * ADDR_W'(ext_h_q) + ADDR_W'(oy_q);
		end
		if (cmd.mul4) begin
			addr_q  <= t2_q * ADDR_W'(ext_w_q) + ADDR_W'(ox_q);
			row_q   <= t2_q * ADDR_W'(ext_w_q) + ADDR_W'(ox_q);
			plane_q <= t2_q * ADDR_W'(ext_w_q) + ADDR_W'(ox_q);
			dx_q    <= '0;
			dy_q    <= '0;
			dz_q    <= '0;
		end else if (cmd.emit) begin
			if (!last_x) begin
				dx_q   <= dx_q + 1'b1;
				addr_q <= addr_q + 1'b1;
			end else if (!last_y) begin
				dx_q   <= '0;
				dy_q   <= dy_q + 1'b1;
				row_q  <= row_next;
				addr_q <= row_next;
			end else begin
				dx_q    <= '0;
				dy_q    <= '0;
				dz_q    <= dz_q + 1'b1;
				plane_q <= plane_next;
				row_q   <= plane_next;
				addr_q  <= plane_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata <= OUT_W'({value_q, addr_q});
			m_tlast <= sts.last_copy;
			m_tuser <= sts.last_copy && last_elem_q;
		end
	end

`ifndef SYNTHESIS
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("tensor end flagged on a copy that does not end its element");
	a_last_copy_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last_copy |=> m_tvalid && m_tlast)
		else $error("final copy of an element left without its end mark");
	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> dx_q < cfg.wf && dy_q < cfg.hf && dz_q < cfg.df)
		else $error("copy counter ran past its factor");
`endif

endmodule

[hdl/tensor_nearest_upsample_3d_core.sv]
// Channel   Direction  Data                                         Side bits
// s_*       in         tdata: sample                                none
// m_*       out        tdata: out_address, out_value               tlast: run_last,
//                                                                   tuser: tensor_done
// cfg_*     in         cfg_index selects, cfg_data holds the value  write only
//
// Each element passes through taking the request, the multiply chain MUL2,
// MUL3, MUL4 that forms the base address, and one copy per cycle while the
// output is free, since the output register takes one result a cycle.
// Reset clears the position counters and sets every configuration register to one.
// A stalled output holds the copy sequence; the next request is taken as soon
// as the final copy of an element sits in the output register.
module tensor_nearest_upsample_3d_core #(
	parameter int MAX_FACTOR = 4,
	parameter int MAX_DIM = 256,
	parameter int MAX_CHANNELS = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              s_tvalid,
	output logic                                              s_tready,
	// sample
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]                   s_tdata,
	output logic                                              m_tvalid,
	input  logic                                              m_tready,
	// out_address, out_value
	output logic [((tnu3d_pkg::ADDR_W+DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic                                              m_tlast,
	// tensor_done
	output logic                                              m_tuser,
	input  logic                                              cfg_wr_en,
	input  logic [tnu3d_pkg::CFG_IDX_W-1:0]                   cfg_index,
	input  logic [tnu3d_pkg::CFG_DATA_W-1:0]                  cfg_data
);
	import tnu3d_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tnu3d_cfg #(
		.MAX_FACTOR  (MAX_FACTOR),
		.MAX_DIM     (MAX_DIM),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tnu3d_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tnu3d_dp #(
		.MAX_DIM     (MAX_DIM),
		.MAX_CHANNELS(MAX_CHANNELS),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.sts     (sts),
		.sample  (s_tdata[DATA_WIDTH-1:0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule
